// ===== design/ipa_pkg.sv =====
// Package for the ID pool allocator: payload structs, command and mode codes,
// register indexes and fixed widths. No dependencies.
package ipa_pkg;

  localparam int ID_W      = 8;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = ID_W + 1;
  localparam int WORD_W    = 16;
  localparam int WB_W      = 4;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_RES_ID    = 2'd1,
    MODE_RES_RANGE = 2'd2,
    MODE_FREE      = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_FIRST = 1'b0,
    CFG_POOL_LAST  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_RES_ID,
    OP_RES_RANGE,
    OP_FREE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id_value;
    logic [ID_W-1:0]   range_last;
  } in_item_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] result_id;
    logic            pool_empty;
    logic            pool_full;
  } out_item_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] last;
  } cmd_t;

  // Pool range as seen by the back end; top is pool_last clipped to the map.
  typedef struct packed {
    logic [ID_W-1:0]  first;
    logic [ID_W-1:0]  top;
    logic [CNT_W-1:0] size;
    logic             refill;
  } cfg_info_t;

endpackage

// ===== design/ipa_fifo.sv =====
// Small register queue used between the allocator stages and at the output.
// Depends on nothing; the entry type is a parameter.
module ipa_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                entries_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== design/ipa_front.sv =====
// Front end of the ID pool allocator: range registers and request checking.
// Depends on ipa_pkg.
module ipa_front #(
  parameter int ID_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ipa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipa_pkg::ID_W-1:0]       cfg_data,
  input  ipa_pkg::in_item_t              in_item,
  output ipa_pkg::cmd_t                  cmd,
  output ipa_pkg::cfg_info_t             cfg_info
);

  localparam int MAP_N = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam logic [ipa_pkg::ID_W-1:0] TOP_ID = ipa_pkg::ID_W'(MAP_N - 1);

  logic [ipa_pkg::ID_W-1:0] first_r, last_r, top;
  logic                     refill_r;
  logic                     id_ok, last_ok;

  assign cfg_ready = 1'b1;
  assign top       = (last_r > TOP_ID) ? TOP_ID : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      last_r   <= '1;
      refill_r <= 1'b0;
    end else begin
      refill_r <= cfg_valid;
      if (cfg_valid) begin
        unique case (ipa_pkg::cfg_idx_t'(cfg_index))
          ipa_pkg::CFG_POOL_FIRST: first_r <= cfg_data;
          ipa_pkg::CFG_POOL_LAST:  last_r  <= cfg_data;
        endcase
      end
    end
  end

  always_comb begin
    cfg_info.first  = first_r;
    cfg_info.top    = top;
    cfg_info.refill = refill_r;
    if (first_r <= top) begin
      cfg_info.size = ipa_pkg::CNT_W'(top - first_r) + 1'b1;
    end else begin
      cfg_info.size = '0;
    end
  end

  assign id_ok   = (in_item.id_value >= first_r) && (in_item.id_value <= top);
  assign last_ok = (in_item.range_last >= first_r) && (in_item.range_last <= top);

  always_comb begin
    cmd.first = in_item.id_value;
    cmd.last  = in_item.range_last;
    unique case (ipa_pkg::mode_t'(in_item.mode))
      ipa_pkg::MODE_ALLOC:  cmd.op = ipa_pkg::OP_ALLOC;
      ipa_pkg::MODE_RES_ID: cmd.op = id_ok ? ipa_pkg::OP_RES_ID : ipa_pkg::OP_REJECT;
      ipa_pkg::MODE_RES_RANGE: begin
        if (id_ok && last_ok && (in_item.id_value <= in_item.range_last)) begin
          cmd.op = ipa_pkg::OP_RES_RANGE;
        end else begin
          cmd.op = ipa_pkg::OP_REJECT;
        end
      end
      ipa_pkg::MODE_FREE:   cmd.op = id_ok ? ipa_pkg::OP_FREE : ipa_pkg::OP_REJECT;
    endcase
  end

endmodule

// ===== design/ipa_back.sv =====
// Back end of the ID pool allocator: the free bitmap in a word memory, the
// free count and the sequencer that carries out checked commands.
// Depends on ipa_pkg.
module ipa_back #(
  parameter int ID_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ipa_pkg::cfg_info_t cfg_info,
  input  logic               cmd_empty,
  input  ipa_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output ipa_pkg::out_item_t res
);

  localparam int MAP_N = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int NW    = (MAP_N + ipa_pkg::WORD_W - 1) / ipa_pkg::WORD_W;
  localparam int WIX_W = (NW > 1) ? $clog2(NW) : 1;
  localparam int MEM_D = 2 ** WIX_W;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EXE, S_OUT} state_t;

  typedef logic [ipa_pkg::WORD_W-1:0] word_t;

  state_t                      state_r, state_nxt;
  logic [WIX_W-1:0]            w_r, w_nxt;
  logic                        pass_r, pass_nxt;
  ipa_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [ipa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        ok_r, ok_nxt;
  logic [ipa_pkg::ID_W-1:0]    rid_r, rid_nxt;

  word_t                       mem [MEM_D];
  word_t                       rdata_r;
  logic                        mem_we;
  word_t                       mem_wdata;

  word_t                       clr_mask, span_mask, id_bit;
  logic [ipa_pkg::WB_W-1:0]    low_bit, span_lo, span_hi;
  logic [WIX_W-1:0]            first_w, last_w, id_w;
  logic [ipa_pkg::CNT_W-1:0]   span_len;

  function automatic logic [WIX_W-1:0] word_of(input logic [ipa_pkg::ID_W-1:0] id);
    return WIX_W'(id >> ipa_pkg::WB_W);
  endfunction

  assign first_w  = word_of(cmd_r.first);
  assign last_w   = word_of(cmd_r.last);
  assign id_w     = word_of(cmd.first);
  assign id_bit   = word_t'(1) << cmd_r.first[ipa_pkg::WB_W-1:0];
  assign span_len = ipa_pkg::CNT_W'(cmd_r.last - cmd_r.first) + 1'b1;

  // Refill pattern for the word under the sweep: ones inside the pool range.
  always_comb begin
    logic [ipa_pkg::ID_W-1:0] id;
    for (int b = 0; b < ipa_pkg::WORD_W; b++) begin
      id = ipa_pkg::ID_W'((int'(w_r) << ipa_pkg::WB_W) + b);
      clr_mask[b] = (id >= cfg_info.first) && (id <= cfg_info.top);
    end
  end

  always_comb begin
    low_bit = '0;
    for (int i = ipa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (rdata_r[i]) begin
        low_bit = ipa_pkg::WB_W'(i);
      end
    end
  end

  // Bits of the current word that fall inside the requested span.
  always_comb begin
    span_lo   = (w_r == first_w) ? cmd_r.first[ipa_pkg::WB_W-1:0] : '0;
    span_hi   = (w_r == last_w) ? cmd_r.last[ipa_pkg::WB_W-1:0] : '1;
    span_mask = ({ipa_pkg::WORD_W{1'b1}} << span_lo)
              & ({ipa_pkg::WORD_W{1'b1}} >> (ipa_pkg::WB_W'(ipa_pkg::WORD_W - 1) - span_hi));
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    pass_nxt  = pass_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    rid_nxt   = rid_r;
    mem_we    = 1'b0;
    mem_wdata = rdata_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res.ok         = ok_r;
    res.result_id  = rid_r;
    res.pool_empty = (cnt_r == '0);
    res.pool_full  = (cfg_info.size != '0) && (cnt_r == cfg_info.size);

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = clr_mask;
        if (w_r == WIX_W'(NW - 1)) begin
          cnt_nxt   = cfg_info.size;
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          ok_nxt  = 1'b0;
          rid_nxt = '0;
          pass_nxt = 1'b0;
          unique case (cmd.op)
            ipa_pkg::OP_ALLOC: begin
              w_nxt     = '0;
              state_nxt = (cnt_r == '0) ? S_OUT : S_RD;
            end
            ipa_pkg::OP_RES_ID, ipa_pkg::OP_FREE: begin
              w_nxt     = id_w;
              state_nxt = S_RD;
            end
            ipa_pkg::OP_RES_RANGE: begin
              w_nxt     = id_w;
              state_nxt = S_RD;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD: state_nxt = S_EXE;
      S_EXE: begin
        unique case (cmd_r.op)
          ipa_pkg::OP_ALLOC: begin
            if (rdata_r != '0) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r & ~(word_t'(1) << low_bit);
              ok_nxt    = 1'b1;
              rid_nxt   = ipa_pkg::ID_W'((int'(w_r) << ipa_pkg::WB_W) + int'(low_bit));
              cnt_nxt   = cnt_r - 1'b1;
              state_nxt = S_OUT;
            end else begin
              w_nxt     = w_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          ipa_pkg::OP_RES_ID: begin
            if ((rdata_r & id_bit) != '0) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r & ~id_bit;
              ok_nxt    = 1'b1;
              cnt_nxt   = cnt_r - 1'b1;
            end
            state_nxt = S_OUT;
          end
          ipa_pkg::OP_FREE: begin
            if ((rdata_r & id_bit) == '0) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r | id_bit;
              ok_nxt    = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
            end
            state_nxt = S_OUT;
          end
          ipa_pkg::OP_RES_RANGE: begin
            // The first pass checks every word of the span; the second clears it.
            if (!pass_r) begin
              if ((rdata_r & span_mask) != span_mask) begin
                state_nxt = S_OUT;
              end else if (w_r == last_w) begin
                pass_nxt  = 1'b1;
                w_nxt     = first_w;
                state_nxt = S_RD;
              end else begin
                w_nxt     = w_r + 1'b1;
                state_nxt = S_RD;
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r & ~span_mask;
              if (w_r == last_w) begin
                ok_nxt    = 1'b1;
                cnt_nxt   = cnt_r - span_len;
                state_nxt = S_OUT;
              end else begin
                w_nxt     = w_r + 1'b1;
                state_nxt = S_RD;
              end
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A range register write restarts the refill sweep.
    if (cfg_info.refill) begin
      state_nxt = S_CLR;
      w_nxt     = '0;
      mem_we    = 1'b0;
      cmd_pop   = 1'b0;
      res_push  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      w_r     <= '0;
      pass_r  <= 1'b0;
      cnt_r   <= '0;
      ok_r    <= 1'b0;
      rid_r   <= '0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
      ok_r    <= ok_nxt;
      rid_r   <= rid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[w_r] <= mem_wdata;
    end
    rdata_r <= mem[w_nxt];
  end

endmodule

// ===== design/id_pool_allocator.sv =====
// Top level of the ID pool allocator: front end, command queue, back end and
// result queue. Depends on ipa_pkg, ipa_front, ipa_fifo and ipa_back.
//
//   Channel   Handshake                  Payload
//   in_       push / full                in_item  (mode, id_value, range_last)
//   out_      pop / empty                out_item (ok, result_id, pool_empty, pool_full)
//   cfg_      valid / ready (always 1)   cfg_index, cfg_data
//
// The free map sits in 16-bit words; the back end reads each word it visits in
// state S_RD and acts on it in S_EXE. Allocate scans from word 0 up to the
// lowest free ID; reserve range checks the span and, if it is all free, walks
// it again to clear it; a refusal or an allocate on an empty pool goes straight to the result.
// Reset or a range register write first starts a refill sweep of the
// ceil(min(ID_COUNT,256)/16) map words; two-entry queues let both sides stall.
module id_pool_allocator #(
  parameter int ID_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  ipa_pkg::in_item_t             in_item,
  output logic                          out_empty,
  input  logic                          out_pop,
  output ipa_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ipa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipa_pkg::ID_W-1:0]      cfg_data
);

  ipa_pkg::cmd_t      cmd_in, cmd_out;
  ipa_pkg::cfg_info_t cfg_info;
  ipa_pkg::out_item_t res;
  logic               cmd_empty, cmd_pop;
  logic               res_full, res_push;

  ipa_front #(.ID_COUNT(ID_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd_in),
    .cfg_info  (cfg_info)
  );

  ipa_fifo #(.T(ipa_pkg::cmd_t), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  ipa_back #(.ID_COUNT(ID_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_info  (cfg_info),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  ipa_fifo #(.T(ipa_pkg::out_item_t), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

// ===== sim/tb_id_pool_allocator.sv =====
// Self-checking testbench for id_pool_allocator: a scoreboard class predicts each
// response from its own free-ID bitmap and pool range. Depends on ipa_pkg and the RTL.
module tb_id_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ipa_pkg::*;

  localparam int MAP_SIZE    = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 88;
  localparam int IN_W        = $bits(in_item_t);

  class id_pool_scoreboard;
    logic [MAP_SIZE-1:0] free_ids;
    logic [ID_W-1:0]     first_id;
    logic [ID_W-1:0]     last_id;
    out_item_t           expected_q[$];
    int                  errors;

    function new();
      first_id = '0;
      last_id  = '1;
      errors   = 0;
      refill();
    endfunction

    function bit in_range(int id);
      return id >= first_id && id <= last_id;
    endfunction

    function void refill();
      for (int i = 0; i < MAP_SIZE; i++) free_ids[i] = in_range(i);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [ID_W-1:0] val);
      if (idx == CFG_POOL_FIRST) first_id = val;
      else last_id = val;
      refill();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endfunction

    // Applies one accepted request to the map and queues the response it must give.
    function void note_request(in_item_t req);
      out_item_t rsp;
      int        lo;
      int        hi;
      bit        any_in;
      bit        all_free;
      rsp = '0;
      lo  = req.id_value;
      hi  = req.range_last;
      case (req.mode)
        MODE_ALLOC: begin
          for (int i = 0; i < MAP_SIZE; i++) begin
            if (free_ids[i]) begin
              free_ids[i]   = 1'b0;
              rsp.ok        = 1'b1;
              rsp.result_id = i[ID_W-1:0];
              break;
            end
          end
        end
        MODE_RES_ID: begin
          if (in_range(lo) && free_ids[lo]) begin
            free_ids[lo] = 1'b0;
            rsp.ok       = 1'b1;
          end
        end
        MODE_RES_RANGE: begin
          if (lo <= hi && in_range(lo) && in_range(hi)) begin
            rsp.ok = 1'b1;
            for (int i = lo; i <= hi; i++) if (!free_ids[i]) rsp.ok = 1'b0;
            if (rsp.ok) for (int i = lo; i <= hi; i++) free_ids[i] = 1'b0;
          end
        end
        default: begin
          if (in_range(lo) && !free_ids[lo]) begin
            free_ids[lo] = 1'b1;
            rsp.ok       = 1'b1;
          end
        end
      endcase
      any_in   = 1'b0;
      all_free = 1'b1;
      for (int i = 0; i < MAP_SIZE; i++) begin
        if (in_range(i)) begin
          any_in = 1'b1;
          if (!free_ids[i]) all_free = 1'b0;
        end
      end
      rsp.pool_empty = ~|free_ids;
      rsp.pool_full  = any_in && all_free;
      expected_q.push_back(rsp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("response with nothing outstanding: %p", got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.ok !== exp.ok || got.result_id !== exp.result_id ||
          got.pool_empty !== exp.pool_empty || got.pool_full !== exp.pool_full)
        report($sformatf("ok %b/%b id %0d/%0d empty %b/%b full %b/%b (got/exp)",
                         got.ok, exp.ok, got.result_id, exp.result_id,
                         got.pool_empty, exp.pool_empty, got.pool_full, exp.pool_full));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_item_t             in_item   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_FIRST;
  logic [ID_W-1:0]      cfg_data  = '0;

  id_pool_scoreboard sb = new();
  int                cur_first = 0;
  int                cur_last  = 255;

  id_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Every transaction is recorded at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_result(out_item);
      if (in_push && !in_full) sb.note_request(in_item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  // Receiver stalls follow their own pattern, switching style at random intervals.
  int pop_style = 0;
  int pop_left  = 0;
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_style = $urandom_range(0, 3);
      pop_left  = $urandom_range(10, 80);
    end
    pop_left--;
    case (pop_style)
      0:       out_pop <= 1'b1;
      1:       out_pop <= 1'($urandom_range(0, 1));
      2:       out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= (pop_left < 8);
    endcase
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_id_pool_allocator: done, errors");
    $finish;
  end

  task automatic send(in_item_t req);
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
  endtask

  task automatic hold_off(int cycles);
    in_push <= 1'b0;
    in_item <= in_item_t'(IN_W'($urandom));
    repeat (cycles) @(posedge clk);
  endtask

  // Stops the sender until every outstanding response has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[ID_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POOL_FIRST) cur_first = val;
    else cur_last = val;
  endtask

  // Both writes go back to back; valid drops once after the second one.
  task automatic set_pool(int first, int last);
    write_reg(CFG_POOL_FIRST, first);
    write_reg(CFG_POOL_LAST, last);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_req(mode_t mode, int id, int last);
    in_item_t r;
    r.mode       = mode;
    r.id_value   = id[ID_W-1:0];
    r.range_last = last[ID_W-1:0];
    return r;
  endfunction

  // Mostly meaningful requests aimed inside the pool, with some raw noise.
  function automatic in_item_t random_req();
    in_item_t r;
    int       lo;
    int       hi;
    int       pick;
    int       top;
    lo   = cur_first;
    hi   = (cur_last >= cur_first) ? cur_last : cur_first;
    pick = $urandom_range(0, 99);
    r.mode       = MODE_W'($urandom_range(0, 3));
    r.id_value   = ID_W'($urandom);
    r.range_last = ID_W'($urandom);
    if (pick < 35) begin
      r.mode = MODE_ALLOC;
    end else if (pick < 65) begin
      // Allocation fills from the bottom, so frees near the low end usually hit.
      r.mode     = MODE_FREE;
      r.id_value = ID_W'($urandom_range(lo, (hi < lo + 31) ? hi : lo + 31));
    end else if (pick < 80) begin
      r.mode     = MODE_RES_ID;
      r.id_value = ID_W'($urandom_range(lo, hi));
    end else if (pick < 95) begin
      r.mode     = MODE_RES_RANGE;
      r.id_value = ID_W'($urandom_range(lo, hi));
      if ($urandom_range(0, 9) == 0) begin
        r.range_last = ID_W'($urandom_range(r.id_value, hi));
      end else begin
        top          = r.id_value + $urandom_range(0, 7);
        r.range_last = ID_W'((top > 255) ? 255 : top);
      end
    end
    return r;
  endfunction

  int phase_first[PHASES] = '{0, 0, 240, 100, 7, 200, 16, 0};
  int phase_last[PHASES]  = '{255, 15, 255, 131, 7, 100, 47, 255};

  initial begin : stimulus
    int burst_left;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full default pool: both ends of the ID space, refusals and full/empty flags.
    send(make_req(MODE_RES_ID, 255, $urandom));
    send(make_req(MODE_RES_ID, 0, $urandom));
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    send(make_req(MODE_RES_ID, 0, $urandom));
    send(make_req(MODE_FREE, 0, $urandom));
    send(make_req(MODE_FREE, 0, $urandom));
    send(make_req(MODE_RES_RANGE, 0, 255));
    send(make_req(MODE_RES_RANGE, 10, 5));
    send(make_req(MODE_FREE, 255, $urandom));
    send(make_req(MODE_FREE, 1, $urandom));
    send(make_req(MODE_RES_RANGE, 0, 255));
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    send(make_req(MODE_FREE, 128, $urandom));
    drain();

    // Narrow pool: IDs and spans outside it, partially used spans, exhaustion.
    set_pool(250, 253);
    send(make_req(MODE_RES_ID, 249, $urandom));
    send(make_req(MODE_FREE, 254, $urandom));
    send(make_req(MODE_RES_RANGE, 249, 251));
    send(make_req(MODE_RES_RANGE, 251, 252));
    send(make_req(MODE_RES_RANGE, 250, 251));
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    drain();

    // First above last leaves no pool at all.
    set_pool(9, 3);
    send(make_req(MODE_ALLOC, $urandom, $urandom));
    send(make_req(MODE_RES_ID, 5, $urandom));
    send(make_req(MODE_FREE, 3, $urandom));
    send(make_req(MODE_RES_RANGE, 3, 9));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_pool(phase_first[p], phase_last[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 24) == 0) drain();
          else hold_off($urandom_range(1, 15));
          burst_left = $urandom_range(1, 40);
        end
        send(random_req());
        burst_left--;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected responses never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_id_pool_allocator: done, clean");
    end else begin
      $display("tb_id_pool_allocator: done, errors");
    end
    $finish;
  end

endmodule
